// ===== rtl/core/snb_pkg.sv =====
`default_nettype none

package snb_pkg;

    // neuron size and lookup table size
    localparam int NUM_INPUTS      = 16;
    localparam int SIGMOID_ENTRIES = 256;
    localparam int SLOTS           = NUM_INPUTS + 1;

    // port widths fixed by the item format
    localparam int REQ_W  = 3;
    localparam int SLOT_W = 5;
    localparam int VAL_W  = 16;
    localparam int GAIN_W = 13;

    // derived widths
    localparam int CNT_W    = $clog2(SLOTS);
    localparam int IN_IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int IDX_W    = $clog2(SIGMOID_ENTRIES);
    localparam int ENT_W    = $clog2(SIGMOID_ENTRIES + 1);
    localparam int SC_W     = VAL_W + ENT_W;
    localparam int MA_W     = 21;
    localparam int MB_W     = 24;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int TMP_W    = 46;
    localparam int ACC_W    = 40;
    localparam int G_W      = 24;
    localparam int PC_W     = 5;

    // fixed point constants
    localparam logic signed [VAL_W-1:0] BIAS_VALUE = -16'sd4096;
    localparam logic signed [16:0]      Q_ONE      = 17'sd4096;
    localparam logic [63:0]             E_INV_Q32  = 64'd1580030169;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET_INPUT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ACTIVATE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELTA     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BACKPROP  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_UPDATE    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd6;

    // multiplier operand a sources
    localparam logic [2:0] MA_IN   = 3'd0;
    localparam logic [2:0] MA_ACT  = 3'd1;
    localparam logic [2:0] MA_OMT  = 3'd2;
    localparam logic [2:0] MA_OPV  = 3'd3;
    localparam logic [2:0] MA_BPLO = 3'd4;
    localparam logic [2:0] MA_BPHI = 3'd5;
    localparam logic [2:0] MA_GAIN = 3'd6;

    // multiplier operand b sources
    localparam logic [2:0] MB_WGT = 3'd0;
    localparam logic [2:0] MB_OMO = 3'd1;
    localparam logic [2:0] MB_G   = 3'd2;
    localparam logic [2:0] MB_DW  = 3'd3;
    localparam logic [2:0] MB_WMP = 3'd4;

    // scratch register operations
    localparam logic [2:0] TMP_HOLD = 3'd0;
    localparam logic [2:0] TMP_CLR  = 3'd1;
    localparam logic [2:0] TMP_LOAD = 3'd2;
    localparam logic [2:0] TMP_ACC  = 3'd3;
    localparam logic [2:0] TMP_BP   = 3'd4;
    localparam logic [2:0] TMP_HI   = 3'd5;
    localparam logic [2:0] TMP_MOM  = 3'd6;

    // result sources
    localparam logic [2:0] RS_ZERO   = 3'd0;
    localparam logic [2:0] RS_ROM    = 3'd1;
    localparam logic [2:0] RS_PROD24 = 3'd2;
    localparam logic [2:0] RS_TMP16  = 3'd3;
    localparam logic [2:0] RS_WRD    = 3'd4;

    // next step selection
    localparam logic [1:0] NX_INC    = 2'd0;
    localparam logic [1:0] NX_LOOP   = 2'd1;
    localparam logic [1:0] NX_JNLAST = 2'd2;

    // program step addresses
    localparam logic [PC_W-1:0] UC_FINISH  = 5'd0;
    localparam logic [PC_W-1:0] UC_SET     = 5'd1;
    localparam logic [PC_W-1:0] UC_LOAD    = 5'd2;
    localparam logic [PC_W-1:0] UC_READ    = 5'd3;
    localparam logic [PC_W-1:0] UC_UPD     = 5'd4;
    localparam logic [PC_W-1:0] UC_UPD_MOM = 5'd5;
    localparam logic [PC_W-1:0] UC_UPD_WR  = 5'd6;
    localparam logic [PC_W-1:0] UC_ACT     = 5'd7;
    localparam logic [PC_W-1:0] UC_ACT_MAC = 5'd8;
    localparam logic [PC_W-1:0] UC_ACT_END = 5'd9;
    localparam logic [PC_W-1:0] UC_ACT_IDX = 5'd10;
    localparam logic [PC_W-1:0] UC_ACT_ROM = 5'd11;
    localparam logic [PC_W-1:0] UC_DELTA   = 5'd12;
    localparam logic [PC_W-1:0] UC_DLT_G   = 5'd13;
    localparam logic [PC_W-1:0] UC_DLT_MUL = 5'd14;
    localparam logic [PC_W-1:0] UC_DLT_OUT = 5'd15;
    localparam logic [PC_W-1:0] UC_BACK    = 5'd16;
    localparam logic [PC_W-1:0] UC_BK_ADD  = 5'd17;
    localparam logic [PC_W-1:0] UC_BK_WR   = 5'd18;
    localparam logic [PC_W-1:0] UC_BK_GMUL = 5'd19;
    localparam logic [PC_W-1:0] UC_BK_G    = 5'd20;
    localparam logic [PC_W-1:0] UC_BK_LO   = 5'd21;
    localparam logic [PC_W-1:0] UC_BK_HI   = 5'd22;
    localparam logic [PC_W-1:0] UC_BK_SUM  = 5'd23;
    localparam logic [PC_W-1:0] UC_BK_OUT  = 5'd24;

    // one control word
    typedef struct packed {
        logic [2:0]      mul_a;
        logic [2:0]      mul_b;
        logic [2:0]      tmp_op;
        logic            wr_in;
        logic            wr_load;
        logic            wr_upd;
        logic            wr_g;
        logic            wr_idx;
        logic            wr_act;
        logic            wr_bp;
        logic            clr_bp;
        logic            cnt_inc;
        logic            addr_cnt;
        logic [2:0]      res_sel;
        logic            fin;
        logic [1:0]      nxt;
        logic [PC_W-1:0] target;
    } uword_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic cnt_end;
        logic last;
    } cond_t;

    // request transfer info from the sequencer
    typedef struct packed {
        logic accept;
        logic bad;
    } disp_t;

    typedef logic signed [VAL_W-1:0] sig_rom_t [SIGMOID_ENTRIES];

    // saturation helpers
    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [TMP_W-1:0] v);
        logic signed [TMP_W-1:0] hi;
        logic signed [TMP_W-1:0] lo;
        hi = TMP_W'(32767);
        lo = TMP_W'(-32768);
        if (v > hi)
            return 16'sh7fff;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat40(input logic signed [TMP_W-1:0] v);
        logic signed [TMP_W-1:0] hi;
        logic signed [TMP_W-1:0] lo;
        hi = TMP_W'(64'sh7f_ffff_ffff);
        lo = TMP_W'(-64'sh80_0000_0000);
        if (v > hi)
            return {1'b0, {(ACC_W-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(ACC_W-1){1'b0}}};
        else
            return v[ACC_W-1:0];
    endfunction

    // slot range check per request
    function automatic logic slot_bad(input logic [REQ_W-1:0] req,
                                      input logic [SLOT_W-1:0] slot);
        logic bad;
        case (req)
            REQ_SET_INPUT: bad = (slot >= SLOT_W'(NUM_INPUTS));
            REQ_LOAD,
            REQ_UPDATE,
            REQ_READ:      bad = (slot > SLOT_W'(NUM_INPUTS));
            default:       bad = 1'b0;
        endcase
        return bad;
    endfunction

    // dispatch table: first step of each request
    function automatic logic [PC_W-1:0] uc_entry(input logic [REQ_W-1:0] req,
                                                 input logic [SLOT_W-1:0] slot);
        logic [PC_W-1:0] e;
        case (req)
            REQ_SET_INPUT: e = UC_SET;
            REQ_LOAD:      e = UC_LOAD;
            REQ_ACTIVATE:  e = UC_ACT;
            REQ_DELTA:     e = UC_DELTA;
            REQ_BACKPROP:  e = UC_BACK;
            REQ_UPDATE:    e = UC_UPD;
            REQ_READ:      e = UC_READ;
            default:       e = UC_FINISH;
        endcase
        if (slot_bad(req, slot))
            e = UC_FINISH;
        return e;
    endfunction

    // control store
    function automatic uword_t uc_rom(input logic [PC_W-1:0] pc);
        uword_t u;
        u = '0;
        case (pc)
            UC_FINISH: begin
                u.fin = 1'b1;
            end
            UC_SET: begin
                u.wr_in = 1'b1;
                u.fin   = 1'b1;
            end
            UC_LOAD: begin
                u.wr_load = 1'b1;
                u.fin     = 1'b1;
            end
            UC_READ: begin
                u.res_sel = RS_WRD;
                u.fin     = 1'b1;
            end
            UC_UPD: begin
                u.mul_a = MA_GAIN;
                u.mul_b = MB_WMP;
            end
            UC_UPD_MOM: begin
                u.tmp_op = TMP_MOM;
            end
            UC_UPD_WR: begin
                u.wr_upd = 1'b1;
                u.fin    = 1'b1;
            end
            UC_ACT: begin
                u.addr_cnt = 1'b1;
                u.mul_a    = MA_IN;
                u.mul_b    = MB_WGT;
                u.cnt_inc  = 1'b1;
                u.tmp_op   = TMP_CLR;
            end
            UC_ACT_MAC: begin
                u.addr_cnt = 1'b1;
                u.mul_a    = MA_IN;
                u.mul_b    = MB_WGT;
                u.cnt_inc  = 1'b1;
                u.tmp_op   = TMP_ACC;
                u.nxt      = NX_LOOP;
                u.target   = UC_ACT_MAC;
            end
            UC_ACT_END: begin
                u.tmp_op = TMP_ACC;
            end
            UC_ACT_IDX: begin
                u.wr_idx = 1'b1;
            end
            UC_ACT_ROM: begin
                u.wr_act  = 1'b1;
                u.res_sel = RS_ROM;
                u.fin     = 1'b1;
            end
            UC_DELTA: begin
                u.mul_a = MA_ACT;
                u.mul_b = MB_OMO;
            end
            UC_DLT_G: begin
                u.wr_g = 1'b1;
            end
            UC_DLT_MUL: begin
                u.mul_a = MA_OMT;
                u.mul_b = MB_G;
            end
            UC_DLT_OUT: begin
                u.res_sel = RS_PROD24;
                u.fin     = 1'b1;
            end
            UC_BACK: begin
                u.mul_a = MA_OPV;
                u.mul_b = MB_DW;
            end
            UC_BK_ADD: begin
                u.tmp_op = TMP_BP;
            end
            UC_BK_WR: begin
                u.wr_bp  = 1'b1;
                u.nxt    = NX_JNLAST;
                u.target = UC_FINISH;
            end
            UC_BK_GMUL: begin
                u.mul_a = MA_ACT;
                u.mul_b = MB_OMO;
            end
            UC_BK_G: begin
                u.wr_g = 1'b1;
            end
            UC_BK_LO: begin
                u.mul_a = MA_BPLO;
                u.mul_b = MB_G;
            end
            UC_BK_HI: begin
                u.tmp_op = TMP_LOAD;
                u.mul_a  = MA_BPHI;
                u.mul_b  = MB_G;
            end
            UC_BK_SUM: begin
                u.tmp_op = TMP_HI;
                u.clr_bp = 1'b1;
            end
            UC_BK_OUT: begin
                u.res_sel = RS_TMP16;
                u.fin     = 1'b1;
            end
            default: begin
                u.fin = 1'b1;
            end
        endcase
        return u;
    endfunction

    // shift-subtract divider, evaluated only while building the sigmoid table
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem  = rem - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid at one Q12 point: taylor exp(-r) times e^-n, then 1/(1+e^-x)
    function automatic logic signed [VAL_W-1:0] sig_point(input logic signed [31:0] p);
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] v;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        t    = (p < 0) ? 64'(-p) : 64'(p);
        n    = t >> 12;
        r    = t & 64'd4095;
        term = 64'd1 << 32;
        v    = term;
        for (int i = 1; i <= 12; i++) begin
            term = udiv64(term * r, 64'(4096 * i));
            if ((i % 2) == 1)
                v = v - term;
            else
                v = v + term;
        end
        for (int j = 0; j < 8; j++) begin
            if (64'(j) < n)
                v = (v * E_INV_Q32) >> 32;
        end
        d = (64'd1 << 32) + v;
        if (p >= 0)
            num = (64'd4096 << 32) + (d >> 1);
        else
            num = 64'd4096 * v + (d >> 1);
        q = udiv64(num, d);
        return q[VAL_W-1:0];
    endfunction

    function automatic sig_rom_t sig_rom_build();
        sig_rom_t rom;
        logic signed [31:0] p;
        for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
            p      = 32'((k * 65536) / SIGMOID_ENTRIES) - 32'sd32768;
            rom[k] = sig_point(p);
        end
        return rom;
    endfunction

    // sigmoid table over [-8, 8)
    localparam sig_rom_t SIG_ROM = sig_rom_build();

endpackage

`default_nettype wire

// ===== rtl/core/snb_seq.sv =====
`default_nettype none

module snb_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [snb_pkg::REQ_W-1:0]   req_type,
    input  logic [snb_pkg::SLOT_W-1:0]  slot_index,
    input  snb_pkg::cond_t              cond,
    output logic                        busy,
    output snb_pkg::uword_t             uw,
    output snb_pkg::disp_t              disp
);
    import snb_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    uword_t          rom_word;

    // control word fetch, null while idle
    assign rom_word = uc_rom(pc_reg);
    assign uw       = busy_reg ? rom_word : '0;

    // request transfer and dispatch
    assign disp.accept = start & ~busy_reg;
    assign disp.bad    = slot_bad(req_type, slot_index);
    assign busy        = busy_reg;

    // step counter and conditional jumps
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (disp.accept)
        begin
            pc_next   = uc_entry(req_type, slot_index);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (uw.fin)
                busy_next = 1'b0;
            case (uw.nxt)
                NX_INC:    pc_next = pc_reg + 1'b1;
                NX_LOOP:   pc_next = cond.cnt_end ? pc_reg + 1'b1 : uw.target;
                NX_JNLAST: pc_next = cond.last ? pc_reg + 1'b1 : uw.target;
                default:   pc_next = pc_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= UC_FINISH;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/snb_dp.sv =====
`default_nettype none

module snb_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [snb_pkg::GAIN_W-1:0]         cfg_wdata,
    input  logic [snb_pkg::SLOT_W-1:0]         slot_index,
    input  logic signed [snb_pkg::VAL_W-1:0]   operand_value,
    input  logic signed [snb_pkg::VAL_W-1:0]   downstream_weight,
    input  logic                               last_term,
    input  snb_pkg::uword_t                    uw,
    input  snb_pkg::disp_t                     disp,
    output snb_pkg::cond_t                     cond,
    output logic signed [snb_pkg::VAL_W-1:0]   result_value,
    output logic                               status,
    output logic                               done
);
    import snb_pkg::*;

    // stores
    logic signed [VAL_W-1:0] in_store_reg [NUM_INPUTS];
    logic signed [VAL_W-1:0] w_store_reg  [SLOTS];
    logic signed [VAL_W-1:0] p_store_reg  [SLOTS];

    // neuron state and config
    logic signed [VAL_W-1:0]  act_reg;
    logic signed [ACC_W-1:0]  bp_reg;
    logic [GAIN_W-1:0]        gain_reg;

    // latched request
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [VAL_W-1:0]  opv_reg;
    logic signed [VAL_W-1:0]  dw_reg;
    logic                     last_reg;
    logic                     bad_reg;

    // working registers
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TMP_W-1:0]  tmp_reg;
    logic signed [TMP_W-1:0]  tmp_next;
    logic signed [G_W-1:0]    g_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;

    // result registers
    logic signed [VAL_W-1:0]  res_reg;
    logic signed [VAL_W-1:0]  res_next;
    logic                     stat_reg;
    logic                     done_reg;

    logic [CNT_W-1:0]         w_idx;
    logic signed [VAL_W-1:0]  in_rd;
    logic signed [VAL_W-1:0]  w_rd;
    logic signed [VAL_W-1:0]  p_rd;
    logic signed [VAL_W-1:0]  rom_rd;
    logic signed [16:0]       o_minus_t;
    logic signed [16:0]       one_minus_o;
    logic signed [16:0]       w_minus_p;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [TMP_W-1:0]  prod_ext;
    logic signed [VAL_W-1:0]  s_sat;
    logic [VAL_W-1:0]         s_off;
    logic [SC_W-1:0]          scaled;

    // store reads
    assign w_idx  = uw.addr_cnt ? cnt_reg : slot_reg[CNT_W-1:0];
    assign in_rd  = (cnt_reg == CNT_W'(NUM_INPUTS)) ? BIAS_VALUE
                                                    : in_store_reg[cnt_reg[IN_IDX_W-1:0]];
    assign w_rd   = w_store_reg[w_idx];
    assign p_rd   = p_store_reg[w_idx];
    assign rom_rd = SIG_ROM[idx_reg];

    // operand differences
    assign o_minus_t   = 17'(act_reg) - 17'(opv_reg);
    assign one_minus_o = Q_ONE - 17'(act_reg);
    assign w_minus_p   = 17'(w_rd) - 17'(p_rd);

    // multiplier operand selection
    always_comb
    begin
        case (uw.mul_a)
            MA_IN:   mul_a = MA_W'(in_rd);
            MA_ACT:  mul_a = MA_W'(act_reg);
            MA_OMT:  mul_a = MA_W'(o_minus_t);
            MA_OPV:  mul_a = MA_W'(opv_reg);
            MA_BPLO: mul_a = {1'b0, bp_reg[19:0]};
            MA_BPHI: mul_a = MA_W'(signed'(bp_reg[ACC_W-1:20]));
            MA_GAIN: mul_a = {{(MA_W-GAIN_W){1'b0}}, gain_reg};
            default: mul_a = '0;
        endcase
        case (uw.mul_b)
            MB_WGT:  mul_b = MB_W'(w_rd);
            MB_OMO:  mul_b = MB_W'(one_minus_o);
            MB_G:    mul_b = g_reg;
            MB_DW:   mul_b = MB_W'(dw_reg);
            MB_WMP:  mul_b = MB_W'(w_minus_p);
            default: mul_b = '0;
        endcase
    end

    assign prod_ext = TMP_W'(prod_reg);

    // scratch register update
    always_comb
    begin
        case (uw.tmp_op)
            TMP_HOLD: tmp_next = tmp_reg;
            TMP_CLR:  tmp_next = '0;
            TMP_LOAD: tmp_next = prod_ext;
            TMP_ACC:  tmp_next = tmp_reg + prod_ext;
            TMP_BP:   tmp_next = TMP_W'(bp_reg) + prod_ext;
            TMP_HI:   tmp_next = prod_ext + (tmp_reg >>> 20);
            TMP_MOM:  tmp_next = TMP_W'(w_rd) + TMP_W'(opv_reg) + (prod_ext >>> 12);
            default:  tmp_next = tmp_reg;
        endcase
    end

    // table index from the saturated sum
    assign s_sat    = sat16(tmp_reg >>> 12);
    assign s_off    = {~s_sat[VAL_W-1], s_sat[VAL_W-2:0]};
    assign scaled   = SC_W'(s_off) * SC_W'(SIGMOID_ENTRIES);
    assign idx_next = scaled[VAL_W +: IDX_W];

    // result selection
    always_comb
    begin
        case (uw.res_sel)
            RS_ZERO:   res_next = '0;
            RS_ROM:    res_next = rom_rd;
            RS_PROD24: res_next = sat16(prod_ext >>> 24);
            RS_TMP16:  res_next = sat16(tmp_reg >>> 16);
            RS_WRD:    res_next = w_rd;
            default:   res_next = '0;
        endcase
    end

    assign cond.cnt_end = (cnt_reg == CNT_W'(SLOTS - 1));
    assign cond.last    = last_reg;

    // request payload and working registers
    always_ff @(posedge clk)
    begin
        if (disp.accept)
        begin
            slot_reg <= slot_index;
            opv_reg  <= operand_value;
            dw_reg   <= downstream_weight;
            last_reg <= last_term;
        end
        prod_reg <= mul_a * mul_b;
        tmp_reg  <= tmp_next;
        if (uw.wr_g)
            g_reg <= prod_reg[G_W-1:0];
        if (uw.wr_idx)
            idx_reg <= idx_next;
        if (uw.fin)
        begin
            res_reg  <= res_next;
            stat_reg <= bad_reg;
        end
    end

    // weight and previous weight stores
    always_ff @(posedge clk)
    begin
        if (uw.wr_load)
        begin
            w_store_reg[w_idx] <= opv_reg;
            p_store_reg[w_idx] <= opv_reg;
        end
        else if (uw.wr_upd)
        begin
            w_store_reg[w_idx] <= sat16(tmp_reg);
            p_store_reg[w_idx] <= w_rd;
        end
    end

    // control and neuron state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_INPUTS; k++)
                in_store_reg[k] <= '0;
            act_reg  <= '0;
            bp_reg   <= '0;
            gain_reg <= '0;
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                gain_reg <= cfg_wdata;
            if (uw.wr_in)
                in_store_reg[slot_reg[IN_IDX_W-1:0]] <= opv_reg;
            if (uw.wr_act)
                act_reg <= rom_rd;
            if (uw.clr_bp)
                bp_reg <= '0;
            else if (uw.wr_bp)
                bp_reg <= sat40(tmp_reg);
            if (disp.accept)
            begin
                cnt_reg <= '0;
                bad_reg <= disp.bad;
            end
            else if (uw.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
            done_reg <= uw.fin;
        end
    end

    assign result_value = res_reg;
    assign status       = stat_reg;
    assign done         = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sigmoid_neuron_backprop_unit_core.sv =====
// steps: done strobes after the last step of the request; steps per request:
//   write input, load weight, read weight, bad slot: 1; update weight: 3;
//   output delta: 4; backprop term: 4, final term 9; activate: NUM_INPUTS + 4
// one request at a time: start is not taken while busy; all steps share the single
//   multiplier stepped by the microprogram, one product per cycle; results cannot be stalled
// reset: asynchronous active low, clears inputs, activation, delta sum and gain
`default_nettype none

module sigmoid_neuron_backprop_unit_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [snb_pkg::REQ_W-1:0]          req_type,
    input  logic [snb_pkg::SLOT_W-1:0]         slot_index,
    input  logic signed [snb_pkg::VAL_W-1:0]   operand_value,
    input  logic signed [snb_pkg::VAL_W-1:0]   downstream_weight,
    input  logic                               last_term,
    input  logic                               cfg_we,
    input  logic [snb_pkg::GAIN_W-1:0]         cfg_wdata,
    output logic                               done,
    output logic signed [snb_pkg::VAL_W-1:0]   result_value,
    output logic                               status
);
    import snb_pkg::*;

    uword_t uw;
    cond_t  cond;
    disp_t  disp;

    // sequencer
    snb_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .slot_index (slot_index),
        .cond       (cond),
        .busy       (busy),
        .uw         (uw),
        .disp       (disp)
    );

    // datapath
    snb_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .slot_index        (slot_index),
        .operand_value     (operand_value),
        .downstream_weight (downstream_weight),
        .last_term         (last_term),
        .uw                (uw),
        .disp              (disp),
        .cond              (cond),
        .result_value      (result_value),
        .status            (status),
        .done              (done)
    );

    // a result strobe comes exactly when the sequencer goes idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sequencer finished without a result");

    // every request takes at least one step
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("start transfer not followed by a busy step");

endmodule

`default_nettype wire

// ===== tb/sigmoid_neuron_backprop_unit_core_checker.sv =====
`timescale 1ns / 100ps

module sigmoid_neuron_backprop_unit_core_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [snb_pkg::REQ_W-1:0]        req_type,
    input  logic [snb_pkg::SLOT_W-1:0]       slot_index,
    input  logic signed [snb_pkg::VAL_W-1:0] operand_value,
    input  logic signed [snb_pkg::VAL_W-1:0] downstream_weight,
    input  logic                             last_term,
    input  logic                             cfg_we,
    input  logic [snb_pkg::GAIN_W-1:0]       cfg_wdata,
    input  logic                             done,
    input  logic signed [snb_pkg::VAL_W-1:0] result_value,
    input  logic                             status,
    output int                               mismatches,
    output int                               pending,
    output int                               checked
);
    import snb_pkg::*;

    localparam longint unsigned EXP_NEG1_Q32 = 64'd1580030169;
    localparam longint          SUM_MAX      = 64'sd549755813887;
    localparam longint          SUM_MIN      = -64'sd549755813888;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    bad_slot;
    } neuron_answer_t;

    // shadow copy of the neuron
    logic signed [VAL_W-1:0]  in_vals  [SLOTS];
    logic signed [VAL_W-1:0]  w_vals   [SLOTS];
    logic signed [VAL_W-1:0]  w_prev   [SLOTS];
    logic signed [VAL_W-1:0]  act_q;
    logic signed [ACC_W-1:0]  delta_sum;
    logic [GAIN_W-1:0]        gain;
    logic signed [VAL_W-1:0]  sig_lut  [SIGMOID_ENTRIES];
    neuron_answer_t           neuron_answers [$];

    // saturate to the q4.12 range
    function automatic logic signed [VAL_W-1:0] clip_q12(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return VAL_W'(v);
    endfunction

    // 1/(1+e^-x) at one q12 point, e^-x from a taylor series and whole powers of e^-1
    function automatic logic signed [VAL_W-1:0] logistic_q12(input longint p);
        longint unsigned mag;
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned term;
        longint unsigned ex;
        longint unsigned den;
        mag   = (p < 0) ? -p : p;
        whole = mag >> 12;
        frac  = mag & 64'd4095;
        term  = 64'd1 << 32;
        ex    = term;
        for (int i = 1; i <= 12; i++)
        begin
            term = term * frac / (64'd4096 * i);
            if (i % 2 == 1)
                ex = ex - term;
            else
                ex = ex + term;
        end
        for (longint unsigned j = 0; j < whole; j++)
            ex = (ex * EXP_NEG1_Q32) >> 32;
        den = (64'd1 << 32) + ex;
        if (p >= 0)
            return VAL_W'(((64'd4096 << 32) + den / 2) / den);
        return VAL_W'((64'd4096 * ex + den / 2) / den);
    endfunction

    // sigmoid table over [-8, 8)
    initial
    begin
        for (int k = 0; k < SIGMOID_ENTRIES; k++)
            sig_lut[k] = logistic_q12((longint'(k) * 65536) / SIGMOID_ENTRIES - 32768);
    end

    task automatic clear_neuron();
        for (int k = 0; k < SLOTS; k++)
        begin
            in_vals[k] = '0;
            w_vals[k]  = '0;
            w_prev[k]  = '0;
        end
        in_vals[NUM_INPUTS] = -16'sd4096;
        act_q     = '0;
        delta_sum = '0;
        gain      = '0;
        neuron_answers.delete();
    endtask

    // one request: update the shadow state and queue the answer it owes
    task automatic step_neuron(input logic [REQ_W-1:0]        req,
                               input logic [SLOT_W-1:0]       slot,
                               input logic signed [VAL_W-1:0] opv,
                               input logic signed [VAL_W-1:0] dw,
                               input logic                    last_flag);
        neuron_answer_t ans;
        longint o;
        longint t;
        longint acc;
        longint mom;
        longint w_old;
        ans.value    = '0;
        ans.bad_slot = 1'b0;
        o = act_q;
        t = opv;
        case (req)
            REQ_SET_INPUT:
            begin
                if (slot < NUM_INPUTS)
                    in_vals[slot] = opv;
                else
                    ans.bad_slot = 1'b1;
            end
            REQ_LOAD:
            begin
                if (slot <= NUM_INPUTS)
                begin
                    w_vals[slot] = opv;
                    w_prev[slot] = opv;
                end
                else
                    ans.bad_slot = 1'b1;
            end
            REQ_ACTIVATE:
            begin
                // exact dot product, then table lookup on the clipped sum
                acc = 0;
                for (int k = 0; k < SLOTS; k++)
                    acc += longint'(in_vals[k]) * longint'(w_vals[k]);
                acc = acc >>> 12;
                if (acc > 32767)
                    acc = 32767;
                else if (acc < -32768)
                    acc = -32768;
                acc = ((acc + 32768) * SIGMOID_ENTRIES) >>> 16;
                if (acc > SIGMOID_ENTRIES - 1)
                    acc = SIGMOID_ENTRIES - 1;
                act_q     = sig_lut[acc];
                ans.value = act_q;
            end
            REQ_DELTA:
            begin
                ans.value = clip_q12(((o - t) * o * (4096 - o)) >>> 24);
            end
            REQ_BACKPROP:
            begin
                acc = longint'(delta_sum) + t * longint'(dw);
                if (acc > SUM_MAX)
                    acc = SUM_MAX;
                else if (acc < SUM_MIN)
                    acc = SUM_MIN;
                delta_sum = ACC_W'(acc);
                if (last_flag)
                begin
                    ans.value = clip_q12((acc * (o * (4096 - o))) >>> 36);
                    delta_sum = '0;
                end
            end
            REQ_UPDATE:
            begin
                if (slot <= NUM_INPUTS)
                begin
                    w_old = w_vals[slot];
                    mom   = (longint'(gain) * (w_old - longint'(w_prev[slot]))) >>> 12;
                    w_vals[slot] = clip_q12(w_old + t + mom);
                    w_prev[slot] = VAL_W'(w_old);
                end
                else
                    ans.bad_slot = 1'b1;
            end
            REQ_READ:
            begin
                if (slot <= NUM_INPUTS)
                    ans.value = w_vals[slot];
                else
                    ans.bad_slot = 1'b1;
            end
            default:
            begin
            end
        endcase
        neuron_answers.push_back(ans);
    endtask

    // watch both channels; results are compared before a new request is queued
    always @(posedge clk or negedge rst_n)
    begin : watch
        neuron_answer_t want;
        if (!rst_n)
        begin
            clear_neuron();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (neuron_answers.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result %0d status %0b with no request outstanding",
                                 $time, result_value, status);
                    mismatches++;
                end
                else
                begin
                    want = neuron_answers.pop_front();
                    if (result_value !== want.value || status !== want.bad_slot)
                    begin
                        if (mismatches < 10)
                            $display("%0t: result %0d status %0b, expected %0d status %0b",
                                     $time, result_value, status, want.value, want.bad_slot);
                        mismatches++;
                    end
                end
                checked++;
            end
            if (cfg_we)
                gain = cfg_wdata;
            if (start && !busy)
                step_neuron(req_type, slot_index, operand_value, downstream_weight, last_term);
            pending = neuron_answers.size();
        end
    end

endmodule

// ===== tb/sigmoid_neuron_backprop_unit_core_tb.sv =====
`timescale 1ns / 100ps

module sigmoid_neuron_backprop_unit_core_tb;
    import snb_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED  = 3'd7;
    localparam int               STALL_LIMIT = 1000;
    localparam int               SAT_CHAIN   = 520;
    localparam int               PHASE_ITEMS = 230;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [REQ_W-1:0]         req_type;
    logic [SLOT_W-1:0]        slot_index;
    logic signed [VAL_W-1:0]  operand_value;
    logic signed [VAL_W-1:0]  downstream_weight;
    logic                     last_term;
    logic                     cfg_we;
    logic [GAIN_W-1:0]        cfg_wdata;
    logic                     done;
    logic signed [VAL_W-1:0]  result_value;
    logic                     status;

    int mismatches;
    int pending;
    int checked;
    int idle_pct;
    int issued;
    int final_terms;
    int gain_writes;
    int idle_cycles;
    int op_count [8];

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sigmoid_neuron_backprop_unit_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .req_type          (req_type),
        .slot_index        (slot_index),
        .operand_value     (operand_value),
        .downstream_weight (downstream_weight),
        .last_term         (last_term),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .done              (done),
        .result_value      (result_value),
        .status            (status)
    );

    sigmoid_neuron_backprop_unit_core_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .req_type          (req_type),
        .slot_index        (slot_index),
        .operand_value     (operand_value),
        .downstream_weight (downstream_weight),
        .last_term         (last_term),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .done              (done),
        .result_value      (result_value),
        .status            (status),
        .mismatches        (mismatches),
        .pending           (pending),
        .checked           (checked)
    );

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic signed [VAL_W-1:0] pick_q12(input int spread);
        int sel;
        int v;
        sel = $urandom_range(9);
        case (sel)
            0:       v = 32767;
            1:       v = -32768;
            2:       v = $urandom;
            default: v = int'($urandom_range(2 * spread)) - spread;
        endcase
        return VAL_W'(v);
    endfunction

    // mostly in range, now and then past the bias slot
    function automatic logic [SLOT_W-1:0] pick_slot(input int top);
        if ($urandom_range(7) == 0)
            return SLOT_W'($urandom_range(31));
        return SLOT_W'($urandom_range(top));
    endfunction

    // one request transfer, with an optional idle burst ahead of it
    task automatic issue(input logic [REQ_W-1:0]        req,
                         input logic [SLOT_W-1:0]       slot,
                         input logic signed [VAL_W-1:0] opv,
                         input logic signed [VAL_W-1:0] dw,
                         input logic                    last_flag);
        logic taken;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(13, 1)) @(negedge clk);
        end
        req_type          <= req;
        slot_index        <= slot;
        operand_value     <= opv;
        downstream_weight <= dw;
        last_term         <= last_flag;
        start             <= 1'b1;
        do
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        while (!taken);
        issued++;
        op_count[req]++;
        if (req == REQ_BACKPROP && last_flag)
            final_terms++;
    endtask

    // gain write once every answer is back and the block has settled
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wdata <= g;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        gain_writes++;
    endtask

    task automatic reload_weights();
        for (int s = 0; s <= NUM_INPUTS; s++)
            issue(REQ_LOAD, SLOT_W'(s), VAL_W'(int'($urandom_range(2048)) - 1024),
                  pick_q12(32767), 1'($urandom));
    endtask

    // inputs, activation, one delta form, weight updates, then now and then a read, a load or an unused request
    task automatic training_pass();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) issue(REQ_SET_INPUT, pick_slot(NUM_INPUTS - 1), pick_q12(2048),
                         pick_q12(4096), 1'($urandom));
        issue(REQ_ACTIVATE, SLOT_W'($urandom), pick_q12(32767), pick_q12(32767),
              1'($urandom));
        if ($urandom_range(1) == 0)
            issue(REQ_DELTA, SLOT_W'($urandom), pick_q12(4096), pick_q12(32767),
                  1'($urandom));
        else
        begin
            n = $urandom_range(5, 1);
            for (int k = 1; k <= n; k++)
                issue(REQ_BACKPROP, SLOT_W'($urandom), pick_q12(8192), pick_q12(8192),
                      (k == n) || ($urandom_range(15) == 0));
        end
        n = $urandom_range(3, 1);
        repeat (n) issue(REQ_UPDATE, pick_slot(NUM_INPUTS), pick_q12(1024),
                         pick_q12(32767), 1'($urandom));
        if ($urandom_range(1) == 0)
            issue(REQ_READ, pick_slot(NUM_INPUTS), pick_q12(32767), pick_q12(32767),
                  1'($urandom));
        if ($urandom_range(7) == 0)
            issue(REQ_LOAD, pick_slot(NUM_INPUTS), pick_q12(2048), pick_q12(32767),
                  1'($urandom));
        if ($urandom_range(15) == 0)
            issue(REQ_UNUSED, SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                  1'($urandom));
    endtask

    // fully random requests, out of order and with stray last flags
    task automatic noise_burst();
        repeat ($urandom_range(6, 1))
            issue(REQ_W'($urandom), SLOT_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom), 1'($urandom));
    endtask

    // enough full-scale terms to pin the delta sum at one end
    task automatic long_backprop(input logic negative);
        for (int k = 1; k <= SAT_CHAIN; k++)
            issue(REQ_BACKPROP, SLOT_W'($urandom), 16'sh8000,
                  negative ? 16'sh7fff : 16'sh8000, k == SAT_CHAIN);
    endtask

    initial
    begin
        logic [GAIN_W-1:0] g;
        int                phase_end;
        rst_n             = 1'b0;
        start             = 1'b0;
        req_type          = '0;
        slot_index        = '0;
        operand_value     = '0;
        downstream_weight = '0;
        last_term         = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        idle_pct          = 0;
        issued            = 0;
        final_terms       = 0;
        gain_writes       = 0;
        idle_cycles       = 0;
        for (int k = 0; k < 8; k++)
            op_count[k] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every weight written before anything reads one
        idle_pct = 20;
        for (int s = 0; s <= NUM_INPUTS; s++)
            issue(REQ_LOAD, SLOT_W'(s),
                  (s == 0) ? 16'sh7fff : (s == 1) ? 16'sh8000 :
                  VAL_W'(int'($urandom_range(2048)) - 1024), 16'sh0000, 1'b0);
        issue(REQ_LOAD, 5'd17, 16'sh1234, 16'sh7fff, 1'b1);
        issue(REQ_LOAD, 5'd31, 16'sh7fff, 16'sh8000, 1'b0);
        // saturated sums at both ends, then a mid-range activation
        issue(REQ_SET_INPUT, 5'd0, 16'sh7fff, 16'sh0000, 1'b0);
        issue(REQ_SET_INPUT, 5'd15, 16'sh8000, 16'sh0000, 1'b0);
        issue(REQ_ACTIVATE, 5'd31, 16'sh0000, 16'sh0000, 1'b0);
        issue(REQ_SET_INPUT, 5'd0, 16'sh8000, 16'sh0000, 1'b0);
        issue(REQ_ACTIVATE, 5'd0, 16'sh7fff, 16'sh7fff, 1'b1);
        issue(REQ_SET_INPUT, 5'd16, 16'sh0100, 16'sh0000, 1'b0);
        issue(REQ_SET_INPUT, 5'd31, 16'sh7fff, 16'sh0000, 1'b0);
        issue(REQ_SET_INPUT, 5'd0, 16'sh0000, 16'sh0000, 1'b0);
        issue(REQ_SET_INPUT, 5'd15, 16'sh0000, 16'sh0000, 1'b0);
        issue(REQ_ACTIVATE, 5'd5, 16'sh0000, 16'sh0000, 1'b0);
        // output delta with extreme targets, backprop with extreme terms
        issue(REQ_DELTA, 5'd0, 16'sh7fff, 16'sh0000, 1'b0);
        issue(REQ_DELTA, 5'd31, 16'sh8000, 16'sh7fff, 1'b1);
        issue(REQ_BACKPROP, 5'd0, 16'sh7fff, 16'sh8000, 1'b0);
        issue(REQ_BACKPROP, 5'd31, 16'sh8000, 16'sh8000, 1'b1);
        // full momentum gain on the bias weight
        write_gain(13'd4096);
        issue(REQ_UPDATE, 5'd16, 16'sh7fff, 16'sh0000, 1'b0);
        issue(REQ_UPDATE, 5'd16, 16'sh8000, 16'sh0000, 1'b0);
        issue(REQ_UPDATE, 5'd17, 16'sh0100, 16'sh0000, 1'b0);
        issue(REQ_READ, 5'd16, 16'sh0000, 16'sh0000, 1'b0);
        issue(REQ_READ, 5'd31, 16'sh0000, 16'sh0000, 1'b0);
        issue(REQ_UNUSED, 5'd31, 16'shffff, 16'shffff, 1'b1);

        // random phases, one gain setting each, the second and the last with no idling
        phase_end = issued;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       g = 13'd0;
                1:       g = 13'd4095;
                2:       g = GAIN_W'($urandom_range(4096));
                3:       g = 13'd1;
                default: g = 13'd4096;
            endcase
            write_gain(g);
            case (ph)
                0:       idle_pct = 25;
                2:       idle_pct = 40;
                3:       idle_pct = 10;
                default: idle_pct = 0;
            endcase
            phase_end += PHASE_ITEMS;
            reload_weights();
            if (ph == 2)
            begin
                training_pass();
                long_backprop(1'($urandom));
            end
            while (issued < phase_end)
            begin
                if ($urandom_range(4) == 0)
                    noise_burst();
                else
                    training_pass();
            end
        end

        // drain
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (24) @(negedge clk);

        $display("%0d requests: %0d activations, %0d output deltas, %0d backprop terms "
                 , issued, op_count[REQ_ACTIVATE], op_count[REQ_DELTA],
                 op_count[REQ_BACKPROP]);
        $display("(%0d final), %0d updates, %0d reads; %0d results over %0d gain settings",
                 final_terms, op_count[REQ_UPDATE], op_count[REQ_READ], checked,
                 gain_writes);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
